### hw/rtl/ure_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
`timescale 1ns / 1ps

package ure_pkg;

  localparam int unsigned TICK_COUNT_BITS_DEF = 17;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_ENABLED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_SETUP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_HIGH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_WAIT_LIM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_HIGH_LIM  = 3'd4;

  localparam logic        RST_SENSOR_ENABLED = 1'b0;
  localparam logic [7:0]  RST_TRIG_SETUP     = 8'd2;
  localparam logic [7:0]  RST_TRIG_HIGH      = 8'd10;
  localparam logic [15:0] RST_ECHO_WAIT_LIM  = 16'd30000;
  localparam logic [15:0] RST_ECHO_HIGH_LIM  = 16'd60000;

  localparam int unsigned DIST_W     = 17;
  localparam logic [16:0] DIST_MULT  = 17'd112394;
  localparam int unsigned DIST_SHIFT = 16;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 24;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SETUP = 3'd1,
    PH_PULSE = 3'd2,
    PH_WAIT  = 3'd3,
    PH_HIGH  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_RISE  = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_DISABLED = 2'd3
  } status_t;

endpackage

### hw/rtl/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger: trigger sequencing, echo timing and distance scaling.
//
//   channel  | dir | beat content
//   ---------+-----+---------------------------------------------------------
//   in_      | in  | one microsecond tick: start request, sampled echo level
//   out_     | out | one result per tick: trigger, done, status, distance
//   cfg_     | in  | register write: enable, setup, pulse, wait/high limits
//
// One beat in, one beat out; a new tick is taken every cycle while the output is not stalled.
// Each tick passes through one layer of logic (counter step, compares and
// a 17-bit constant multiply) into the output register.
// Synchronous active-low reset: idle phase, count zero, registers to defaults.
// in_tready stays high while the output register is empty or being drained.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger #(
  parameter int unsigned TICK_COUNT_BITS = ure_pkg::TICK_COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [0] start_req, [1] echo_level, [7:2] zero
  input  logic [ure_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] trigger_level, [1] done_res, [3:2] status, [20:4] distance_centi_cm,
  // [23:21] zero
  output logic [ure_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_we,
  input  logic [ure_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ure_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int unsigned CW = (TICK_COUNT_BITS > 16) ? TICK_COUNT_BITS : 16;
  localparam int unsigned PW = TICK_COUNT_BITS + 17;
  localparam int unsigned SHW = PW - ure_pkg::DIST_SHIFT;
  localparam int unsigned SW = (SHW > ure_pkg::DIST_W) ? SHW : ure_pkg::DIST_W;
  localparam logic [TICK_COUNT_BITS-1:0] CNT_MAX = '1;

  logic        enabled_r;
  logic [7:0]  setup_r;
  logic [7:0]  pulse_r;
  logic [15:0] wait_lim_r;
  logic [15:0] high_lim_r;

  ure_pkg::phase_t               phase_r, phase_nxt;
  logic [TICK_COUNT_BITS-1:0]    cnt_r, cnt_nxt;

  logic                          out_valid_r;
  logic                          trig_r, trig_nxt;
  logic                          done_r, done_nxt;
  ure_pkg::status_t              status_r, status_nxt;
  logic [ure_pkg::DIST_W-1:0]    dist_r, dist_nxt;

  logic                          in_fire;
  logic                          start;
  logic                          echo;
  logic [TICK_COUNT_BITS-1:0]    cnt_bump;
  logic                          cnt_at_max;
  logic [CW-1:0]                 bump_c;
  logic [PW-1:0]                 prod;
  logic [SW-1:0]                 sh_ext;
  logic [ure_pkg::DIST_W-1:0]    dist_calc;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign start     = in_tdata[0];
  assign echo      = in_tdata[1];

  assign cnt_at_max = (cnt_bump == CNT_MAX);
  assign cnt_bump   = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
  assign bump_c     = CW'(cnt_bump);
  assign prod       = PW'(cnt_bump) * PW'(ure_pkg::DIST_MULT);
  assign sh_ext     = SW'(prod[PW-1:ure_pkg::DIST_SHIFT]);
  assign dist_calc  = (sh_ext > SW'({ure_pkg::DIST_W{1'b1}})) ? '1
                                                               : sh_ext[ure_pkg::DIST_W-1:0];

  // next state
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    case (phase_r)
      ure_pkg::PH_IDLE: begin
        cnt_nxt = '0;
        if (start && enabled_r) begin
          phase_nxt = (setup_r == 8'd0) ? ure_pkg::PH_PULSE : ure_pkg::PH_SETUP;
        end
      end
      ure_pkg::PH_SETUP: begin
        cnt_nxt = cnt_bump;
        if (bump_c >= CW'(setup_r)) begin
          phase_nxt = ure_pkg::PH_PULSE;
          cnt_nxt   = '0;
        end
      end
      ure_pkg::PH_PULSE: begin
        cnt_nxt = cnt_bump;
        if (bump_c >= CW'(pulse_r)) begin
          phase_nxt = ure_pkg::PH_WAIT;
          cnt_nxt   = '0;
        end
      end
      ure_pkg::PH_WAIT: begin
        if (echo) begin
          phase_nxt = ure_pkg::PH_HIGH;
          cnt_nxt   = '0;
        end else if (bump_c > CW'(wait_lim_r) || cnt_at_max) begin
          phase_nxt = ure_pkg::PH_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_bump;
        end
      end
      ure_pkg::PH_HIGH: begin
        if (!echo || bump_c > CW'(high_lim_r) || cnt_at_max) begin
          phase_nxt = ure_pkg::PH_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_bump;
        end
      end
      default: begin
        phase_nxt = ure_pkg::PH_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  // result fields
  always_comb begin
    trig_nxt   = 1'b0;
    done_nxt   = 1'b0;
    status_nxt = ure_pkg::ST_OK;
    dist_nxt   = '0;
    case (phase_r)
      ure_pkg::PH_IDLE: begin
        if (start && !enabled_r) begin
          done_nxt   = 1'b1;
          status_nxt = ure_pkg::ST_DISABLED;
        end
      end
      ure_pkg::PH_SETUP: begin
        trig_nxt = 1'b0;
      end
      ure_pkg::PH_PULSE: begin
        trig_nxt = 1'b1;
      end
      ure_pkg::PH_WAIT: begin
        if (!echo && (bump_c > CW'(wait_lim_r) || cnt_at_max)) begin
          done_nxt   = 1'b1;
          status_nxt = ure_pkg::ST_NO_RISE;
        end
      end
      ure_pkg::PH_HIGH: begin
        if (!echo) begin
          done_nxt = 1'b1;
          dist_nxt = dist_calc;
        end else if (bump_c > CW'(high_lim_r) || cnt_at_max) begin
          done_nxt   = 1'b1;
          status_nxt = ure_pkg::ST_TOO_LONG;
        end
      end
      default: begin
        trig_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r  <= ure_pkg::RST_SENSOR_ENABLED;
      setup_r    <= ure_pkg::RST_TRIG_SETUP;
      pulse_r    <= ure_pkg::RST_TRIG_HIGH;
      wait_lim_r <= ure_pkg::RST_ECHO_WAIT_LIM;
      high_lim_r <= ure_pkg::RST_ECHO_HIGH_LIM;
    end else if (cfg_we) begin
      case (cfg_index)
        ure_pkg::REG_SENSOR_ENABLED: enabled_r  <= cfg_wdata[0];
        ure_pkg::REG_TRIG_SETUP:     setup_r    <= cfg_wdata[7:0];
        ure_pkg::REG_TRIG_HIGH:      pulse_r    <= cfg_wdata[7:0];
        ure_pkg::REG_ECHO_WAIT_LIM:  wait_lim_r <= cfg_wdata;
        ure_pkg::REG_ECHO_HIGH_LIM:  high_lim_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ure_pkg::PH_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r     <= phase_nxt;
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      trig_r   <= trig_nxt;
      done_r   <= done_nxt;
      status_r <= status_nxt;
      dist_r   <= dist_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, dist_r, status_r, done_r, trig_r};

`ifndef ASSERT_OFF
  a_disabled_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && phase_r == ure_pkg::PH_IDLE && start && !enabled_r) |=>
      (out_valid_r && done_r && status_r == ure_pkg::ST_DISABLED))
    else $error("disabled start did not report at once");

  a_done_trig_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && done_r) |-> !trig_r)
    else $error("trigger high on a finished measurement");

  a_err_no_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != ure_pkg::ST_OK) |-> (dist_r == '0))
    else $error("distance nonzero on an error result");

  a_high_exit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && phase_r == ure_pkg::PH_HIGH) |=>
      (phase_r == ure_pkg::PH_HIGH || done_r))
    else $error("left echo-high phase without a result");
`endif

endmodule

### bench/echo_range_checker.sv
// Checker that predicts and compares every result beat of the echo ranger.
`timescale 1ns / 1ps

module echo_range_checker
  import ure_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [0] start_req, [1] echo_level
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // [0] trigger, [1] done, [3:2] status, [20:4] dist
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     mismatches,
  output int                     pending
);

  localparam int unsigned CW = TICK_COUNT_BITS_DEF;
  localparam logic [CW-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic              trigger;
    logic              done;
    status_t           status;
    logic [DIST_W-1:0] distance;
  } ranging_t;

  ranging_t      range_q[$];
  phase_t        phase = PH_IDLE;
  logic [CW-1:0] ticks = '0;
  logic          sensor_en = RST_SENSOR_ENABLED;
  logic [7:0]    setup_us = RST_TRIG_SETUP;
  logic [7:0]    pulse_us = RST_TRIG_HIGH;
  logic [15:0]   wait_lim = RST_ECHO_WAIT_LIM;
  logic [15:0]   high_lim = RST_ECHO_HIGH_LIM;
  int            errs = 0;

  function automatic logic [CW-1:0] bumped(input logic [CW-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  task automatic step_ranger(input logic start, input logic echo);
    ranging_t           r;
    logic [CW+DIST_W-1:0] prod;
    r.trigger  = 1'b0;
    r.done     = 1'b0;
    r.status   = ST_OK;
    r.distance = '0;
    case (phase)
      PH_SETUP: begin
        ticks = bumped(ticks);
        if (ticks >= setup_us) begin
          phase = PH_PULSE;
          ticks = '0;
        end
      end
      PH_PULSE: begin
        r.trigger = 1'b1;
        ticks = bumped(ticks);
        if (ticks >= pulse_us) begin
          phase = PH_WAIT;
          ticks = '0;
        end
      end
      PH_WAIT: begin
        if (echo) begin
          phase = PH_HIGH;
          ticks = '0;
        end else begin
          ticks = bumped(ticks);
          if (ticks > wait_lim || ticks == COUNT_MAX) begin
            r.done   = 1'b1;
            r.status = ST_NO_RISE;
            phase    = PH_IDLE;
            ticks    = '0;
          end
        end
      end
      PH_HIGH: begin
        ticks = bumped(ticks);
        if (!echo) begin
          prod = ticks * DIST_MULT;
          prod = prod >> DIST_SHIFT;
          r.distance = (prod > {DIST_W{1'b1}}) ? {DIST_W{1'b1}} : prod[DIST_W-1:0];
          r.done   = 1'b1;
          r.status = ST_OK;
          phase    = PH_IDLE;
          ticks    = '0;
        end else if (ticks > high_lim || ticks == COUNT_MAX) begin
          r.done   = 1'b1;
          r.status = ST_TOO_LONG;
          phase    = PH_IDLE;
          ticks    = '0;
        end
      end
      default: begin
        phase = PH_IDLE;
        ticks = '0;
        if (start && !sensor_en) begin
          r.done   = 1'b1;
          r.status = ST_DISABLED;
        end else if (start) begin
          phase = (setup_us == 0) ? PH_PULSE : PH_SETUP;
        end
      end
    endcase
    range_q.push_back(r);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errs++;
      $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    ranging_t want;
    if (!rst_n) begin
      range_q.delete();
      phase     = PH_IDLE;
      ticks     = '0;
      sensor_en = RST_SENSOR_ENABLED;
      setup_us  = RST_TRIG_SETUP;
      pulse_us  = RST_TRIG_HIGH;
      wait_lim  = RST_ECHO_WAIT_LIM;
      high_lim  = RST_ECHO_HIGH_LIM;
    end else begin
      if (out_tvalid && out_tready) begin
        if (range_q.size() == 0) begin
          errs++;
          $display("%0t: result beat expected none, actual %h", $time, out_tdata);
        end else begin
          want = range_q.pop_front();
          check_field("trigger_level", want.trigger, out_tdata[0]);
          check_field("done_res", want.done, out_tdata[1]);
          check_field("status", want.status, out_tdata[3:2]);
          check_field("distance_centi_cm", want.distance, out_tdata[20:4]);
        end
      end
      if (in_tvalid && in_tready) step_ranger(in_tdata[0], in_tdata[1]);
      if (cfg_we) begin
        case (cfg_index)
          REG_SENSOR_ENABLED: sensor_en = cfg_wdata[0];
          REG_TRIG_SETUP:     setup_us  = cfg_wdata[7:0];
          REG_TRIG_HIGH:      pulse_us  = cfg_wdata[7:0];
          REG_ECHO_WAIT_LIM:  wait_lim  = cfg_wdata[15:0];
          REG_ECHO_HIGH_LIM:  high_lim  = cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
    mismatches <= errs;
    pending    <= range_q.size();
  end

endmodule

### bench/tb_ultrasonic_echo_ranger.sv
// Top-level testbench for the ultrasonic echo ranger: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_ultrasonic_echo_ranger;
  import ure_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
  int                     mismatches;
  int                     pending;

  int          burst_left = 0;
  int          sent = 0;
  int          stall_mode = 0;
  int          stall_left = 0;
  logic [7:0]  cur_setup = RST_TRIG_SETUP;
  logic [7:0]  cur_pulse = RST_TRIG_HIGH;
  logic [15:0] cur_wait = RST_ECHO_WAIT_LIM;
  logic [15:0] cur_high = RST_ECHO_HIGH_LIM;

  ultrasonic_echo_ranger i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  echo_range_checker i_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 4) != 0);
      default: out_tready <= ($urandom_range(0, 2) == 0);
    endcase
  end

  function automatic logic one_in(input int n);
    return $urandom_range(0, n - 1) == 0;
  endfunction

  task automatic send_tick(input logic start, input logic echo);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = one_in(4) ? $urandom_range(1, 8) : 0;
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-2){1'b0}}, echo, start};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic en, input logic [7:0] setup,
                              input logic [7:0] pulse, input logic [15:0] wlim,
                              input logic [15:0] hlim);
    drain();
    write_reg(REG_SENSOR_ENABLED, {15'd0, en});
    write_reg(REG_TRIG_SETUP, {8'd0, setup});
    write_reg(REG_TRIG_HIGH, {8'd0, pulse});
    write_reg(REG_ECHO_WAIT_LIM, wlim);
    write_reg(REG_ECHO_HIGH_LIM, hlim);
    cfg_we <= 1'b0;
    cur_setup = setup;
    cur_pulse = pulse;
    cur_wait  = wlim;
    cur_high  = hlim;
  endtask

  task automatic run_ping(input int wait_ticks, input int high_ticks);
    int trig_ticks;
    trig_ticks = cur_setup + ((cur_pulse == 0) ? 1 : cur_pulse);
    send_tick(1'b1, 1'b0);
    repeat (trig_ticks) send_tick(one_in(4), one_in(4));
    repeat (wait_ticks) send_tick(one_in(4), 1'b0);
    repeat (high_ticks) send_tick(one_in(4), 1'b1);
    send_tick(one_in(4), 1'b0);
  endtask

  task automatic random_ping();
    int w;
    int h;
    int w_cap;
    int h_cap;
    w_cap = (cur_wait > 40) ? 40 : cur_wait;
    h_cap = (cur_high > 59) ? 60 : cur_high + 1;
    if (cur_wait <= 1000 && one_in(6)) w = cur_wait + 1;
    else if (one_in(8)) w = w_cap;
    else w = $urandom_range(0, w_cap);
    if (cur_high <= 1000 && one_in(6)) h = cur_high + 2;
    else if (one_in(8)) h = h_cap;
    else h = $urandom_range(1, h_cap);
    run_ping(w, h);
  endtask

  task automatic random_phase(input int budget);
    int stop;
    stop = sent + budget;
    while (sent < stop) begin
      if (one_in(5)) repeat ($urandom_range(1, 12)) send_tick(one_in(2), one_in(2));
      else random_ping();
    end
    if (one_in(2)) begin
      send_tick(1'b1, 1'b0);
      repeat ($urandom_range(0, 6)) send_tick(1'b0, 1'b0);
    end
  endtask

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    program_regs(1'b1, 8'd0, 8'd0, 16'd1, 16'd1);
    run_ping(0, 1);
    run_ping(2, 0);
    run_ping(0, 3);
    run_ping(1, 2);

    program_regs(1'b1, 8'd2, 8'd10, 16'd20, 16'd30);
    random_phase(150);
    program_regs(1'b1, 8'd0, 8'd1, 16'd1, 16'd1);
    random_phase(150);
    program_regs(1'b0, 8'd3, 8'd3, 16'd10, 16'd10);
    random_phase(100);
    program_regs(1'b1, 8'd255, 8'd255, 16'd8, 16'd16);
    random_phase(225);
    repeat (3) begin
      program_regs(1'b1, 8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
                   16'($urandom_range(1, 40)), 16'($urandom_range(1, 60)));
      random_phase(150);
    end
    program_regs(1'b1, 8'd1, 8'd0, 16'd65535, 16'd65535);
    run_ping(3, 60);
    random_phase(100);
    program_regs(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 16'($urandom_range(1, 30)),
                 16'($urandom_range(1, 50)));
    random_phase(150);

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
